### hw/rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and helper functions for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Input token kinds
  localparam logic [2:0] TK_NUM    = 3'd0;
  localparam logic [2:0] TK_BIN    = 3'd1;
  localparam logic [2:0] TK_FUNC   = 3'd2;
  localparam logic [2:0] TK_OPEN   = 3'd3;
  localparam logic [2:0] TK_CLOSE  = 3'd4;
  localparam logic [2:0] TK_END    = 3'd5;
  localparam logic [2:0] TK_UMINUS = 3'd6;
  localparam logic [2:0] TK_UPLUS  = 3'd7;

  // Stack entry kinds
  localparam logic [2:0] EK_OPEN   = 3'd0;
  localparam logic [2:0] EK_BIN    = 3'd1;
  localparam logic [2:0] EK_FUNC   = 3'd2;
  localparam logic [2:0] EK_UMINUS = 3'd3;
  localparam logic [2:0] EK_UPLUS  = 3'd4;

  // Result kinds
  localparam logic [2:0] OK_NUM    = 3'd0;
  localparam logic [2:0] OK_BIN    = 3'd1;
  localparam logic [2:0] OK_FUNC   = 3'd2;
  localparam logic [2:0] OK_UMINUS = 3'd3;
  localparam logic [2:0] OK_UPLUS  = 3'd4;
  localparam logic [2:0] OK_END    = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CLOSE = 2'd1;
  localparam logic [1:0] ERR_OPEN  = 2'd2;
  localparam logic [1:0] ERR_OVF   = 2'd3;

  // Operator / function codes
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_POW = 4'd5;
  localparam logic [3:0] OP_MAX = 4'd5;
  localparam logic [3:0] FN_MAX = 4'd8;

  // Priorities
  localparam logic [2:0] PRIO_OPEN = 3'd0;
  localparam logic [2:0] PRIO_ADD  = 3'd2;
  localparam logic [2:0] PRIO_MUL  = 3'd3;
  localparam logic [2:0] PRIO_POW  = 3'd4;
  localparam logic [2:0] PRIO_TOP  = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] code;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [31:0] tag;
  } token_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [31:0] tag;
    logic [1:0]  err;
  } result_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    entry_t entry;
  } stk_cmd_t;

  typedef struct packed {
    entry_t top;
    logic   empty;
    logic   full;
    logic   open_any;
  } stk_stat_t;

  typedef struct packed {
    logic    push;
    logic    finish;
    result_t res;
  } emit_cmd_t;

  function automatic logic [2:0] entry_prio(entry_t e);
    logic [2:0] p;
    if (e.kind == EK_OPEN) begin
      p = PRIO_OPEN;
    end else if (e.kind == EK_BIN) begin
      if (e.code <= OP_SUB) p = PRIO_ADD;
      else if (e.code <= OP_MOD) p = PRIO_MUL;
      else p = PRIO_POW;
    end else begin
      p = PRIO_TOP;
    end
    return p;
  endfunction

  function automatic result_t entry_result(entry_t e);
    result_t r;
    r.tag = '0;
    r.err = ERR_NONE;
    r.code = (e.kind == EK_BIN || e.kind == EK_FUNC) ? e.code : 4'd0;
    if (e.kind == EK_BIN) r.kind = OK_BIN;
    else if (e.kind == EK_FUNC) r.kind = OK_FUNC;
    else if (e.kind == EK_UMINUS) r.kind = OK_UMINUS;
    else r.kind = OK_UPLUS;
    return r;
  endfunction

endpackage

### hw/rtl/itp_tok_if.sv
// ----------------------------------------------------------------------------
// itp_tok_if
// Infix token channel: valid/ready plus one lexed token.
// ----------------------------------------------------------------------------
interface itp_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [3:0]  symbol_code;
  logic [31:0] operand_tag;

  modport source(output valid, output token_kind, output symbol_code,
                 output operand_tag, input ready);
  modport sink(input valid, input token_kind, input symbol_code,
               input operand_tag, output ready);
endinterface

### hw/rtl/itp_pfx_if.sv
// ----------------------------------------------------------------------------
// itp_pfx_if
// Postfix result channel: valid/ready plus one postfix item.
// ----------------------------------------------------------------------------
interface itp_pfx_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [3:0]  out_code;
  logic [31:0] out_tag;
  logic [1:0]  error_code;
  logic        last;

  modport source(output valid, output out_kind, output out_code, output out_tag,
                 output error_code, output last, input ready);
  modport sink(input valid, input out_kind, input out_code, input out_tag,
               input error_code, input last, output ready);
endinterface

### hw/rtl/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: lexed infix tokens in, postfix items out.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                       Handshake
//  --------  ---  --------------------------------------------  ---------
//  token     in   token_kind, symbol_code, operand_tag          valid/ready
//  postfix   out  out_kind, out_code, out_tag, error_code, last valid/ready
//
//  Sequence: a token is taken while idle, then decoded; a binary op first pops
//    entries of higher priority (or equal, unless it is pow), a close paren pops
//    through its open paren, and end pops all entries (none on an error).
//  Reset: rst is synchronous; stack count, error latch and sequencer clear.
//  Stalls: token.ready is high only while the sequencer is idle; a stalled
//    postfix channel holds the sequencer wherever it would emit an item.
//
module infix_to_postfix_converter_top (
  input logic      clk,
  input logic      rst,
  itp_tok_if.sink  token,
  itp_pfx_if.source postfix
);

  itp_pkg::token_t    tok;
  itp_pkg::stk_cmd_t  scmd;
  itp_pkg::stk_stat_t stat;
  itp_pkg::emit_cmd_t ecmd;
  itp_pkg::result_t   res;
  logic               erdy;
  logic               tok_ready;
  logic               res_valid;
  logic               res_last;

  // pack the incoming token
  assign tok.kind = token.token_kind;
  assign tok.code = token.symbol_code;
  assign tok.tag  = token.operand_tag;
  assign token.ready = tok_ready;

  // sequencer: decides each stack operation and what gets emitted
  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (token.valid),
    .tok_ready (tok_ready),
    .tok_in    (tok),
    .stat      (stat),
    .scmd      (scmd),
    .erdy      (erdy),
    .ecmd      (ecmd)
  );

  // operator stack
  itp_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (scmd),
    .stat (stat)
  );

  // hold slot + output register; sets last when the item is finished
  itp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ecmd),
    .rdy       (erdy),
    .out_valid (res_valid),
    .out_ready (postfix.ready),
    .out_res   (res),
    .out_last  (res_last)
  );

  assign postfix.valid      = res_valid;
  assign postfix.out_kind   = res.kind;
  assign postfix.out_code   = res.code;
  assign postfix.out_tag    = res.tag;
  assign postfix.error_code = res.err;
  assign postfix.last       = res_last;

endmodule

### hw/rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack: entry registers, fill count and open-paren count.
// ----------------------------------------------------------------------------
module itp_stack (
  input  logic               clk,
  input  logic               rst,
  input  itp_pkg::stk_cmd_t  cmd,
  output itp_pkg::stk_stat_t stat
);

  itp_pkg::entry_t            mem [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]  count;
  logic [itp_pkg::CNT_W-1:0]  opens;
  logic [itp_pkg::IDX_W-1:0]  top_idx;
  logic [itp_pkg::CNT_W-1:0]  count_dec;

  assign count_dec = count - itp_pkg::CNT_W'(1);
  assign top_idx   = count_dec[itp_pkg::IDX_W-1:0];

  always_comb begin
    stat.top      = mem[top_idx];
    stat.empty    = (count == '0);
    stat.full     = (count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    stat.open_any = (opens != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      opens <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      opens <= '0;
    end else if (cmd.pop) begin
      count <= count_dec;
      if (stat.top.kind == itp_pkg::EK_OPEN) opens <= opens - itp_pkg::CNT_W'(1);
    end else if (cmd.push) begin
      count <= count + itp_pkg::CNT_W'(1);
      if (cmd.entry.kind == itp_pkg::EK_OPEN) opens <= opens + itp_pkg::CNT_W'(1);
    end
  end

  // push is only issued below full, so count fits the index width
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.pop && !cmd.clear) begin
      mem[count[itp_pkg::IDX_W-1:0]] <= cmd.entry;
    end
  end

endmodule

### hw/rtl/itp_emit.sv
// ----------------------------------------------------------------------------
// itp_emit
// Result staging: one hold slot plus the output register. The hold slot
// delays each result until it is known whether another one follows, so
// the last flag can be set.
// ----------------------------------------------------------------------------
module itp_emit (
  input  logic                clk,
  input  logic                rst,
  input  itp_pkg::emit_cmd_t  cmd,
  output logic                rdy,
  output logic                out_valid,
  input  logic                out_ready,
  output itp_pkg::result_t    out_res,
  output logic                out_last
);

  logic             hold_v;
  itp_pkg::result_t hold;
  logic             move;

  assign rdy  = !out_valid || out_ready;
  assign move = rdy && hold_v && (cmd.push || cmd.finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold_v    <= 1'b0;
    end else begin
      if (move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (rdy && cmd.push) hold_v <= 1'b1;
      else if (rdy && cmd.finish) hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res  <= hold;
      out_last <= cmd.finish;
    end
    if (rdy && cmd.push) hold <= cmd.res;
  end

endmodule

### hw/rtl/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl
// Token sequencer: at most one stack operation per cycle, priority compare on top.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  itp_pkg::token_t     tok_in,
  input  itp_pkg::stk_stat_t  stat,
  output itp_pkg::stk_cmd_t   scmd,
  input  logic                erdy,
  output itp_pkg::emit_cmd_t  ecmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_EXEC      = 8'b0000_0010,
    S_BIN_POP   = 8'b0000_0100,
    S_CLOSE_POP = 8'b0000_1000,
    S_CLOSE_FN  = 8'b0001_0000,
    S_END_POP   = 8'b0010_0000,
    S_END_RES   = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t          state, state_next;
  itp_pkg::token_t tok;
  logic [1:0]      err, err_next;
  logic [1:0]      sticky, sticky_next;

  logic            push_req;
  itp_pkg::entry_t push_entry;
  logic [2:0]      new_prio;
  logic [2:0]      top_prio;
  logic            bin_pop;

  assign tok_ready = (state == S_IDLE);

  always_comb begin
    new_prio = itp_pkg::entry_prio('{kind: itp_pkg::EK_BIN, code: tok.code});
    top_prio = itp_pkg::entry_prio(stat.top);
    bin_pop  = !stat.empty && (stat.top.kind != itp_pkg::EK_OPEN) &&
               ((top_prio > new_prio) ||
                ((top_prio == new_prio) && (tok.code != itp_pkg::OP_POW)));
  end

  always_comb begin
    state_next  = state;
    err_next    = err;
    sticky_next = sticky;
    scmd        = '0;
    ecmd        = '0;
    push_req    = 1'b0;
    push_entry  = '0;

    unique case (state)
      S_IDLE: begin
        if (tok_valid) state_next = S_EXEC;
      end

      S_EXEC: begin
        if (tok.kind == itp_pkg::TK_END) begin
          if (sticky != itp_pkg::ERR_NONE) err_next = sticky;
          else if (stat.open_any) err_next = itp_pkg::ERR_OPEN;
          else err_next = itp_pkg::ERR_NONE;
          if (sticky != itp_pkg::ERR_NONE || stat.open_any) begin
            scmd.clear = 1'b1;
            state_next = S_END_RES;
          end else begin
            state_next = S_END_POP;
          end
        end else if (sticky != itp_pkg::ERR_NONE) begin
          state_next = S_IDLE;
        end else begin
          case (tok.kind)
            itp_pkg::TK_NUM: begin
              if (erdy) begin
                ecmd.push     = 1'b1;
                ecmd.res.kind = itp_pkg::OK_NUM;
                ecmd.res.code = 4'd0;
                ecmd.res.tag  = tok.tag;
                ecmd.res.err  = itp_pkg::ERR_NONE;
                state_next    = S_FINISH;
              end
            end
            itp_pkg::TK_BIN: begin
              state_next = (tok.code > itp_pkg::OP_MAX) ? S_IDLE : S_BIN_POP;
            end
            itp_pkg::TK_FUNC: begin
              push_req   = (tok.code <= itp_pkg::FN_MAX);
              push_entry = '{kind: itp_pkg::EK_FUNC, code: tok.code};
              state_next = S_IDLE;
            end
            itp_pkg::TK_CLOSE: begin
              if (!stat.open_any) begin
                scmd.clear  = 1'b1;
                sticky_next = itp_pkg::ERR_CLOSE;
                state_next  = S_IDLE;
              end else begin
                state_next  = S_CLOSE_POP;
              end
            end
            itp_pkg::TK_OPEN: begin
              push_req   = 1'b1;
              push_entry = '{kind: itp_pkg::EK_OPEN, code: 4'd0};
              state_next = S_IDLE;
            end
            itp_pkg::TK_UMINUS: begin
              push_req   = 1'b1;
              push_entry = '{kind: itp_pkg::EK_UMINUS, code: 4'd0};
              state_next = S_IDLE;
            end
            default: begin
              push_req   = 1'b1;
              push_entry = '{kind: itp_pkg::EK_UPLUS, code: 4'd0};
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_BIN_POP: begin
        if (bin_pop) begin
          if (erdy) begin
            scmd.pop  = 1'b1;
            ecmd.push = 1'b1;
            ecmd.res  = itp_pkg::entry_result(stat.top);
          end
        end else begin
          push_req   = 1'b1;
          push_entry = '{kind: itp_pkg::EK_BIN, code: tok.code};
          state_next = S_FINISH;
        end
      end

      S_CLOSE_POP: begin
        if (stat.top.kind == itp_pkg::EK_OPEN) begin
          scmd.pop   = 1'b1;
          state_next = S_CLOSE_FN;
        end else if (erdy) begin
          scmd.pop  = 1'b1;
          ecmd.push = 1'b1;
          ecmd.res  = itp_pkg::entry_result(stat.top);
        end
      end

      S_CLOSE_FN: begin
        if (!stat.empty && stat.top.kind == itp_pkg::EK_FUNC) begin
          if (erdy) begin
            scmd.pop   = 1'b1;
            ecmd.push  = 1'b1;
            ecmd.res   = itp_pkg::entry_result(stat.top);
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_FINISH;
        end
      end

      S_END_POP: begin
        if (stat.empty) begin
          state_next = S_END_RES;
        end else if (erdy) begin
          scmd.pop  = 1'b1;
          ecmd.push = 1'b1;
          ecmd.res  = itp_pkg::entry_result(stat.top);
        end
      end

      S_END_RES: begin
        if (erdy) begin
          ecmd.push     = 1'b1;
          ecmd.res.kind = itp_pkg::OK_END;
          ecmd.res.code = 4'd0;
          ecmd.res.tag  = '0;
          ecmd.res.err  = err;
          scmd.clear    = 1'b1;
          sticky_next   = itp_pkg::ERR_NONE;
          state_next    = S_FINISH;
        end
      end

      S_FINISH: begin
        if (erdy) begin
          ecmd.finish = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // a push onto a full stack drops the stack and latches overflow
    if (push_req) begin
      if (stat.full) begin
        scmd.clear  = 1'b1;
        sticky_next = itp_pkg::ERR_OVF;
      end else begin
        scmd.push  = 1'b1;
        scmd.entry = push_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sticky <= itp_pkg::ERR_NONE;
    end else begin
      state  <= state_next;
      sticky <= sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    err <= err_next;
    if (tok_valid && tok_ready) tok <= tok_in;
  end

endmodule
